### hw/rtl/kda_pkg.sv
// shared types and constants for the key debounce / auto-repeat / lockout block
`timescale 1ns / 1ps
`default_nettype none

package kda_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_DEBOUNCE_LIMIT = 2'd0;
   localparam logic [1:0] CSR_REPEAT_MASK    = 2'd1;
   localparam logic [1:0] CSR_GROUP_IDS      = 2'd2;

   // register reset values
   localparam logic [15:0] DEBOUNCE_LIMIT_RST = 16'd2;
   localparam logic [3:0]  REPEAT_MASK_RST    = 4'd0;
   localparam logic [31:0] GROUP_IDS_RST      = 32'h0002_0100;

   // hold timer saturation and repeat band edges
   localparam logic [15:0] HOLD_MAX    = 16'hFFFF;
   localparam logic [15:0] HOLD_BAND_1 = 16'd2000;
   localparam logic [15:0] HOLD_BAND_2 = 16'd5000;
   localparam logic [15:0] HOLD_BAND_3 = 16'd8000;
   localparam logic [15:0] HOLD_BAND_4 = 16'd11000;

   // repeat periods per band
   localparam logic [8:0] PERIOD_1 = 9'd500;
   localparam logic [8:0] PERIOD_2 = 9'd100;
   localparam logic [8:0] PERIOD_3 = 9'd20;
   localparam logic [8:0] PERIOD_4 = 9'd4;

   typedef struct packed {
      logic [31:0] group_ids;
      logic [3:0]  repeat_mask;
      logic [15:0] debounce_limit;
   } cfg_type;

   typedef struct packed {
      logic       remote_level;
      logic       remote_enable;
      logic       raw_level;
      logic [1:0] key_index;
   } req_type;

   typedef struct packed {
      logic [15:0] hold_ticks;
      logic        locked_out;
      logic        release_event;
      logic        press_event;
      logic        key_down;
      logic [1:0]  key_number;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/kda_csr.sv
// configuration registers with write decode
`timescale 1ns / 1ps
`default_nettype none

module kda_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_wr_en,
   input  wire logic [1:0]      csr_index,
   input  wire logic [31:0]     csr_wr_data,
   output kda_pkg::cfg_type     cfg
);
   import kda_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEBOUNCE_LIMIT: cfg_in.debounce_limit = csr_wr_data[15:0];
            CSR_REPEAT_MASK:    cfg_in.repeat_mask    = csr_wr_data[3:0];
            CSR_GROUP_IDS:      cfg_in.group_ids      = csr_wr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_limit <= DEBOUNCE_LIMIT_RST;
         cfg_ff.repeat_mask    <= REPEAT_MASK_RST;
         cfg_ff.group_ids      <= GROUP_IDS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hw/rtl/kda_engine.sv
// per-key state with its debounce, repeat and lockout update
`timescale 1ns / 1ps
`default_nettype none

module kda_engine #(
   parameter int NUM_KEYS = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire kda_pkg::req_type req,
   input  wire kda_pkg::cfg_type cfg,
   output kda_pkg::rsp_type      rsp
);
   import kda_pkg::*;

   logic        lvl_ff  [NUM_KEYS];
   logic [15:0] cnt_ff  [NUM_KEYS];
   logic [15:0] hold_ff [NUM_KEYS];
   logic [8:0]  rep_ff  [NUM_KEYS];
   logic [7:0]  lock_ff;

   logic        lvl_in;
   logic [15:0] cnt_in;
   logic [15:0] hold_in;
   logic [8:0]  rep_in;
   logic [7:0]  lock_in;
   logic        key_ok;

   always_comb begin
      logic        cur_lvl;
      logic [15:0] cur_cnt;
      logic [15:0] cur_hold;
      logic [8:0]  cur_rep;
      logic [7:0]  id;
      logic        rep_on;
      logic        blocked;
      logic        sample;
      logic [15:0] hold_inc;
      logic [8:0]  period;
      logic        press;
      logic        release_ev;

      cur_lvl  = 1'b0;
      cur_cnt  = '0;
      cur_hold = '0;
      cur_rep  = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (32'(req.key_index) == k) begin
            cur_lvl  = lvl_ff[k];
            cur_cnt  = cnt_ff[k];
            cur_hold = hold_ff[k];
            cur_rep  = rep_ff[k];
         end
      end

      key_ok   = (32'(req.key_index) < NUM_KEYS);
      id       = 8'(cfg.group_ids >> {req.key_index, 3'b000});
      rep_on   = cfg.repeat_mask[req.key_index];
      blocked  = (lock_ff != 8'd0) && (id != 8'd0) && (id != lock_ff);
      sample   = req.remote_enable ? req.remote_level : ~req.raw_level;
      hold_inc = (cur_hold != HOLD_MAX) ? cur_hold + 16'd1 : cur_hold;

      if (hold_inc < HOLD_BAND_2)      period = PERIOD_1;
      else if (hold_inc < HOLD_BAND_3) period = PERIOD_2;
      else if (hold_inc < HOLD_BAND_4) period = PERIOD_3;
      else                             period = PERIOD_4;

      lvl_in     = cur_lvl;
      cnt_in     = cfg.debounce_limit;
      hold_in    = cur_hold;
      rep_in     = cur_rep;
      lock_in    = lock_ff;
      press      = 1'b0;
      release_ev = 1'b0;

      if (!blocked) begin
         hold_in = hold_inc;
         if (sample == cur_lvl) begin
            if (rep_on && cur_lvl) begin
               if (hold_inc < HOLD_BAND_1) begin
                  rep_in = PERIOD_1;
               end else if (cur_rep != 9'd0) begin
                  rep_in = cur_rep - 9'd1;
               end else begin
                  rep_in = period;
                  press  = 1'b1;
               end
            end
         end else if (cur_cnt != 16'd0) begin
            cnt_in = cur_cnt - 16'd1;
         end else begin
            // accepted level change
            hold_in = '0;
            lvl_in  = sample;
            if (sample) begin
               press = 1'b1;
               if (id != 8'd0) lock_in = id;
            end else begin
               release_ev = 1'b1;
               if (id != 8'd0) lock_in = 8'd0;
            end
         end
      end

      rsp.key_number    = req.key_index;
      rsp.key_down      = key_ok & lvl_in;
      rsp.press_event   = key_ok & press;
      rsp.release_event = key_ok & release_ev;
      rsp.locked_out    = key_ok & blocked;
      rsp.hold_ticks    = key_ok ? hold_in : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            lvl_ff[k]  <= 1'b0;
            cnt_ff[k]  <= DEBOUNCE_LIMIT_RST;
            hold_ff[k] <= '0;
            rep_ff[k]  <= '0;
         end
         lock_ff <= '0;
      end else if (step_en && key_ok) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (32'(req.key_index) == k) begin
               lvl_ff[k]  <= lvl_in;
               cnt_ff[k]  <= cnt_in;
               hold_ff[k] <= hold_in;
               rep_ff[k]  <= rep_in;
            end
         end
         lock_ff <= lock_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/key_debounce_autorepeat_lockout_top.sv
// top level: input register, key state engine, result register, csr block
`timescale 1ns / 1ps
`default_nettype none

//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | req_tdata: key index, pin, remote select, remote level
//  rsp     | out | rsp_tvalid/tready    | rsp_tdata: key, down, press, release, lockout, hold
//  csr     | in  | csr_wr_en            | csr_index, csr_wr_data, no read-back
//
//  one word per cycle sustained while rsp_tready stays high; a word passes the input register, then the result register
//  the state read-modify-write for the sampled key happens in the cycle the word leaves
//  the input register, so back-to-back words on the same key see updated state
//  reset is synchronous, active high: clears the valid flags of both registers, key state and csr values
//  a stalled result holds; the input register keeps taking words while the result waits
//  until both registers are full, then req_tready drops

module key_debounce_autorepeat_lockout_top #(
   parameter int NUM_KEYS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // key_index[1:0], raw_level, remote_enable, remote_level, pad
   // result stream
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,   // key_number[1:0], key_down, press_event, release_event,
                                         // locked_out, hold_ticks[15:0], pad
   // configuration writes
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wr_data
);
   import kda_pkg::*;

   cfg_type cfg;

   // input register
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   req_type in_data_in;

   // result register
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   rsp_type eng_rsp;
   logic    step_fire;

   // a word moves on when the result register is empty or being drained
   assign step_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_fire;

   kda_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   kda_engine #(
      .NUM_KEYS (NUM_KEYS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_fire),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (eng_rsp)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_data_in  = req_tdata[4:0];
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_rsp;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

endmodule

`default_nettype wire

### hw/rtl/kda_checker.sv
// port-level checks on the result stream, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module kda_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // nothing valid right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // a frozen key reports no events
   a_lock_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5] |-> !rsp_tdata[3] && !rsp_tdata[4])
      else $error("event on locked-out key");

   // release leaves the key up with a fresh hold timer
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> !rsp_tdata[2] && !rsp_tdata[3] && (rsp_tdata[21:6] == 16'd0))
      else $error("bad release word");

   // press only on a down key
   a_press: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2])
      else $error("press on key that is up");

endmodule

bind key_debounce_autorepeat_lockout_top kda_checker u_kda_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### tb/sv/key_debounce_autorepeat_lockout_checker.sv
// checker: predicts key reports from accepted words and compares them with the result stream
`timescale 1ns / 1ps

module key_debounce_autorepeat_lockout_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // key_index[1:0], raw_level, remote_enable, remote_level
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,   // key_number[1:0], key_down, press_event, release_event,
                                         // locked_out, hold_ticks[15:0]
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wr_data,
   output int               fail_count,
   output int               pending
);
   import kda_pkg::*;

   // register copies
   logic [15:0] db_limit;
   logic [3:0]  rpt_mask;
   logic [31:0] grp_ids;

   // per-key state and the shared lockout
   logic        db_level [4];
   logic [15:0] db_cnt   [4];
   logic [15:0] hold     [4];
   logic [8:0]  rpt_cnt  [4];
   logic [7:0]  owner;

   rsp_type report_q [$];
   rsp_type got, want;

   // one sampling tick: updates the key state, returns the report it gives
   function automatic rsp_type next_key_report(input req_type w);
      rsp_type    r;
      logic [1:0] k;
      logic [7:0] gid;
      logic       smp;
      logic [8:0] period;
      r = '0;
      k = w.key_index;
      r.key_number = k;
      gid = grp_ids[8*k +: 8];
      if (owner != 8'd0 && gid != 8'd0 && gid != owner) begin
         db_cnt[k] = db_limit;
         r.key_down = db_level[k];
         r.locked_out = 1'b1;
         r.hold_ticks = hold[k];
         return r;
      end
      smp = w.remote_enable ? w.remote_level : ~w.raw_level;
      if (hold[k] != HOLD_MAX) hold[k] = hold[k] + 16'd1;
      if (smp == db_level[k]) begin
         db_cnt[k] = db_limit;
         if (rpt_mask[k] && db_level[k]) begin
            if (hold[k] < HOLD_BAND_1) begin
               rpt_cnt[k] = PERIOD_1;
            end else begin
               if (hold[k] < HOLD_BAND_2) period = PERIOD_1;
               else if (hold[k] < HOLD_BAND_3) period = PERIOD_2;
               else if (hold[k] < HOLD_BAND_4) period = PERIOD_3;
               else period = PERIOD_4;
               if (rpt_cnt[k] != 9'd0) begin
                  rpt_cnt[k] = rpt_cnt[k] - 9'd1;
               end else begin
                  rpt_cnt[k] = period;
                  r.press_event = 1'b1;
               end
            end
         end
      end else if (db_cnt[k] != 16'd0) begin
         db_cnt[k] = db_cnt[k] - 16'd1;
      end else begin
         hold[k] = 16'd0;
         db_level[k] = smp;
         if (smp) begin
            r.press_event = 1'b1;
            if (gid != 8'd0) owner = gid;
         end else begin
            r.release_event = 1'b1;
            if (gid != 8'd0) owner = 8'd0;
         end
         db_cnt[k] = db_limit;
      end
      r.key_down = db_level[k];
      r.hold_ticks = hold[k];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         db_limit = DEBOUNCE_LIMIT_RST;
         rpt_mask = REPEAT_MASK_RST;
         grp_ids = GROUP_IDS_RST;
         for (int k = 0; k < 4; k++) begin
            db_level[k] = 1'b0;
            db_cnt[k] = DEBOUNCE_LIMIT_RST;
            hold[k] = 16'd0;
            rpt_cnt[k] = 9'd0;
         end
         owner = 8'd0;
         report_q.delete();
         fail_count = 0;
         pending <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DEBOUNCE_LIMIT: db_limit = csr_wr_data[15:0];
               CSR_REPEAT_MASK:    rpt_mask = csr_wr_data[3:0];
               CSR_GROUP_IDS:      grp_ids = csr_wr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            report_q.push_back(next_key_report(req_type'(req_tdata[4:0])));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[21:0]);
            if (report_q.size() == 0) begin
               if (fail_count < 10)
                  $display({"unexpected key report: key %0d down %0b press %0b",
                            " release %0b lock %0b hold %0d"},
                           got.key_number, got.key_down, got.press_event, got.release_event,
                           got.locked_out, got.hold_ticks);
               fail_count = fail_count + 1;
            end else begin
               want = report_q.pop_front();
               if (got.key_number !== want.key_number || got.key_down !== want.key_down ||
                   got.press_event !== want.press_event ||
                   got.release_event !== want.release_event ||
                   got.locked_out !== want.locked_out || got.hold_ticks !== want.hold_ticks) begin
                  if (fail_count < 10) begin
                     $display({"key report mismatch: expected key %0d down %0b press %0b",
                               " release %0b lock %0b hold %0d"},
                              want.key_number, want.key_down, want.press_event,
                              want.release_event, want.locked_out, want.hold_ticks);
                     $display({"                          got key %0d down %0b press %0b",
                               " release %0b lock %0b hold %0d"},
                              got.key_number, got.key_down, got.press_event,
                              got.release_event, got.locked_out, got.hold_ticks);
                  end
                  fail_count = fail_count + 1;
               end
            end
         end
         pending <= report_q.size();
      end
   end

endmodule

### tb/sv/tb.sv
// testbench top: drives key ticks and register writes, stalls the result side, gives the verdict
`timescale 1ns / 1ps

module tb;
   import kda_pkg::*;

   // generous ceiling: every word waiting out the longest sender gap and result stall,
   // taken several times over
   localparam int CYCLE_LIMIT = 200_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;     // key_index[1:0], raw_level, remote_enable, remote_level
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;             // key_number[1:0], key_down, press_event, release_event,
                                       // locked_out, hold_ticks[15:0]
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_DEBOUNCE_LIMIT;
   logic [31:0] csr_wr_data = 32'h0;

   int fail_count;
   int pending;
   int cycle_count = 0;

   // idling knobs, changed per phase; zero gives a stretch with no idling
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int stall_left = 0;
   int cur_limit = 2;

   key_debounce_autorepeat_lockout_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   key_debounce_autorepeat_lockout_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side back-pressure: random stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic req_type make_word(input logic [1:0] k, input logic raw,
                                         input logic ren, input logic rlev);
      return req_type'({rlev, ren, raw, k});
   endfunction

   // a tick whose sampled level is 'down', through the pin or the remote override at random;
   // the unused source carries a random value
   function automatic req_type sample_word(input logic [1:0] k, input logic down);
      if ($urandom_range(0, 1))
         return make_word(k, 1'($urandom), 1'b1, down);
      return make_word(k, ~down, 1'b0, 1'($urandom));
   endfunction

   function automatic logic [7:0] pick_id();
      case ($urandom_range(0, 4))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h02;
         3: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // maybe an idle burst, then one word held until the block takes it;
   // tvalid stays high on return so back-to-back words need no second assignment
   task automatic push_word(input req_type w);
      int n;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         n = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tdata <= {3'b000, w};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop sending and wait until every predicted report has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // all three registers, only while idle; unused upper data bits carry noise
   task automatic program_regs(input logic [15:0] lim, input logic [3:0] mask,
                               input logic [31:0] ids);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DEBOUNCE_LIMIT;
      csr_wr_data <= {16'($urandom), lim};
      @(posedge clock);
      csr_index <= CSR_REPEAT_MASK;
      csr_wr_data <= {28'($urandom), mask};
      @(posedge clock);
      csr_index <= CSR_GROUP_IDS;
      csr_wr_data <= ids;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_limit = lim;
   endtask

   // a run of ticks on one key at one level, with an occasional opposite sample
   task automatic hold_key(input logic [1:0] k, input logic down, input int n,
                           input int glitch_pct);
      for (int i = 0; i < n; i++)
         push_word(sample_word(k, ($urandom_range(0, 99) < glitch_pct) ? ~down : down));
   endtask

   // run length around the debounce limit: sometimes one short, so the change is not taken
   function automatic int run_len();
      if (cur_limit > 8) return $urandom_range(1, 6);
      return cur_limit + $urandom_range(0, 4);
   endfunction

   // two passes over the keys: the first frees the lockout holder, the second then
   // reaches grouped keys that were frozen behind it
   task automatic release_all();
      int n;
      n = ((cur_limit > 8) ? 8 : cur_limit) + 2;
      repeat (2)
         for (int k = 0; k < 4; k++) hold_key(2'(k), 1'b0, n, 0);
   endtask

   // mostly well-formed press / release runs, some with a competing key in the middle,
   // the rest random words
   task automatic run_phase(input int items);
      int         sent;
      int         n;
      logic [1:0] k, j;
      sent = 0;
      while (sent < items) begin
         k = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 99) < 75) begin
            n = run_len();
            hold_key(k, 1'b1, n, 4);
            sent += n;
            if ($urandom_range(0, 99) < 40) begin
               j = 2'($urandom_range(0, 3));
               n = run_len();
               hold_key(j, 1'b1, n, 4);
               sent += n;
               n = run_len();
               hold_key(j, 1'b0, n, 4);
               sent += n;
            end
            n = run_len();
            hold_key(k, 1'b0, n, 4);
            sent += n;
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) push_word(req_type'(5'($urandom)));
            sent += n;
         end
      end
   endtask

   initial begin
      logic [1:0] other;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed ticks at reset settings: key 1 has id 1, key 2 id 2, keys 0 and 3 ungrouped
      send_idle_pct = 20;
      rsp_stall_pct = 20;
      repeat (3) push_word(make_word(2'd0, 1'b0, 1'b0, 1'b0));  // pin low, press on third tick
      push_word(make_word(2'd0, 1'b1, 1'b0, 1'b1));             // single glitch is absorbed
      push_word(make_word(2'd0, 1'b0, 1'b0, 1'b0));
      repeat (3) push_word(make_word(2'd1, 1'b1, 1'b1, 1'b1));  // remote press takes lockout
      push_word(make_word(2'd2, 1'b0, 1'b0, 1'b0));             // other group frozen
      repeat (3) push_word(make_word(2'd3, 1'b1, 1'b1, 1'b1));  // ungrouped key unaffected
      repeat (3) push_word(make_word(2'd1, 1'b0, 1'b1, 1'b0));  // remote release, pin ignored
      repeat (3) push_word(make_word(2'd2, 1'b0, 1'b0, 1'b1));  // now key 2 takes lockout
      push_word(make_word(2'd1, 1'b0, 1'b0, 1'b0));             // key 1 frozen
      repeat (3) push_word(make_word(2'd2, 1'b1, 1'b0, 1'b0));
      repeat (3) push_word(make_word(2'd0, 1'b1, 1'b0, 1'b0));
      release_all();

      // long hold on key 2 with repeat enabled, the repeat counter kept loaded;
      // key 2 owns the lockout so key 0 is frozen, keys 1 and 3 get stray ticks
      drain();
      program_regs(16'd3, 4'hF, 32'h0005_0007);
      send_idle_pct = 10;
      rsp_stall_pct = 10;
      for (int i = 0; i < 700; i++) begin
         if (i == 350) begin
            drain();                 // sender holds off until every report is back
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         if ($urandom_range(0, 99) < 5) begin
            other = 2'($urandom_range(0, 2));
            if (other == 2'd2) other = 2'd3;
            push_word(req_type'({3'($urandom), other}));
         end else begin
            push_word(sample_word(2'd2, ($urandom_range(0, 99) < 1) ? 1'b0 : 1'b1));
         end
      end
      release_all();

      // random phases over register settings, extremes first
      for (int p = 0; p < 8; p++) begin
         drain();
         case (p)
            0: program_regs(16'd0, 4'hF, 32'h0403_0201);
            1: program_regs(16'hFFFF, 4'h0, 32'hFFFF_FFFF);
            2: program_regs(16'd1, 4'($urandom), 32'h0000_0000);
            3: program_regs(16'd2, 4'h0, 32'hFFFF_FFFF);
            default: program_regs(16'($urandom_range(0, 4)), 4'($urandom),
                                  {pick_id(), pick_id(), pick_id(), pick_id()});
         endcase
         // phase 3 and the closing phase run without idling on either side
         send_idle_pct = (p == 3 || p == 7) ? 0 : 12;
         rsp_stall_pct = (p == 3 || p == 7) ? 0 : 12;
         run_phase((p == 1) ? 40 : 70);
         release_all();
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
